@@ rtl/rc4hsc_pkg.sv @@
// ============================================================================
// rc4hsc_pkg
// Shared types, codes and helper functions of the RC4 hex stream cipher.
// ============================================================================
`default_nettype none

package rc4hsc_pkg;

    localparam int KEY_BITS = 256;

    // Work command handed from the character front end to the cipher core
    typedef struct packed {
        logic       ksa;    // run the key schedule first
        logic       pair;   // one byte to encipher, two results
        logic       last;   // message ends with this command
        logic       ovf;    // characters were dropped
        logic [7:0] data;   // decoded byte
    } cmd_t;

    // Key configuration as seen by the core
    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [5:0]          len;
    } key_cfg_t;

    // Queue status toward the producer and consumer
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_KEY_WORD_0 = 3'd0,
        REG_KEY_WORD_1 = 3'd1,
        REG_KEY_WORD_2 = 3'd2,
        REG_KEY_WORD_3 = 3'd3,
        REG_KEY_LENGTH = 3'd4
    } reg_idx_t;

    // Core sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_INIT,
        ST_KSA_RD_I,
        ST_KSA_RD_J,
        ST_KSA_WR_I,
        ST_KSA_WR_J,
        ST_GEN_RD_I,
        ST_GEN_RD_J,
        ST_GEN_WR_I,
        ST_GEN_WR_J,
        ST_GEN_RD_K,
        ST_OUT_HI,
        ST_OUT_LO,
        ST_OUT_END
    } state_t;

    localparam logic [5:0] KEY_LEN_RESET = 6'd16;
    localparam logic [7:0] ASCII_ZERO    = 8'h30;
    localparam logic [7:0] ASCII_NINE    = 8'h39;
    localparam logic [7:0] ASCII_UPPER_A = 8'h41;
    localparam logic [7:0] ASCII_UPPER_F = 8'h46;
    localparam logic [7:0] CASE_BIT      = 8'h20;

    // ASCII character to nibble; anything that is not hex reads as zero
    function automatic logic [3:0] hex_decode(input logic [7:0] c);
        logic [7:0] u;
        logic [3:0] n;
        u = c & ~CASE_BIT;
        n = 4'd0;
        if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
            n = 4'(c - ASCII_ZERO);
        end
        else if (u >= ASCII_UPPER_A && u <= ASCII_UPPER_F) begin
            n = 4'(u - ASCII_UPPER_A + 8'd10);
        end
        return n;
    endfunction

    // Nibble to lowercase ASCII hex character
    function automatic logic [7:0] hex_encode(input logic [3:0] n);
        logic [7:0] c;
        if (n < 4'd10) begin
            c = ASCII_ZERO + {4'd0, n};
        end
        else begin
            c = 8'h57 + {4'd0, n};
        end
        return c;
    endfunction

endpackage

`default_nettype wire

@@ rtl/rc4_hex_stream_cipher.sv @@
// ============================================================================
// rc4_hex_stream_cipher
// RC4 stream cipher over hex-encoded messages with an APB key register port.
// ============================================================================
// Feed a message one ASCII character per transaction, with is_last on the
// final character. The first character of each message starts a fresh RC4
// key schedule over key_word_0..3 (key byte 0 in the low bits of key_word_0)
// and key_length bytes (0 is used as 1, anything above MAX_KEY_BYTES is
// clamped). Every two characters form one byte, high nibble first; a non-hex
// character counts as zero. Each byte is XORed with the next keystream byte
// and comes back as two lowercase hex characters, high nibble first. The
// last result of a message carries end_of_message; if the message ended on
// an unpaired character, that last result is empty (has_char low). Past
// MAX_MESSAGE_CHARS characters the rest are dropped without output and the
// last result raises overflow.
// Timing: while the queue has room, the front end takes one character per
// cycle into a four-entry command queue, so stalls on the result side do
// not reach the input until the queue fills. The core runs everything
// through one 256-byte state memory with one read and one write port: the
// key schedule is an identity fill of all 256 entries and then 256 swap
// steps (read S[i], read S[j], write S[i], write S[j]); one enciphered byte
// takes a dispatch from the queue, the same four memory steps plus a
// keystream read, and then one hex result per nibble before the next command.
// Registers are 64 bits wide at byte address 8*index (key_length at 0x20);
// write them only while the block is idle.
// ============================================================================
`default_nettype none

module rc4_hex_stream_cipher
    import rc4hsc_pkg::*;
#(
    parameter int MAX_MESSAGE_CHARS = 512,
    parameter int MAX_KEY_BYTES     = 32
)
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    // APB configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output      logic [63:0] prdata,
    output      logic        pready,

    // character input channel
    input  wire logic        char_valid,
    output      logic        char_stall,
    input  wire logic [7:0]  hex_char,
    input  wire logic        is_last,

    // result channel
    output      logic        res_valid,
    input  wire logic        res_stall,
    output      logic [7:0]  out_char,
    output      logic        has_char,
    output      logic        end_of_message,
    output      logic        overflow
);

    logic [63:0] key_word_reg [4];
    logic [5:0]  key_length_reg;

    logic      wr_en;
    reg_idx_t  reg_idx;
    key_cfg_t  key_cfg;

    logic      accept;
    logic      push;
    cmd_t      push_cmd;
    logic      pop;
    cmd_t      head;
    q_status_t q_status;

    // register file: write on the access phase, pready is never held low
    assign pready  = 1'b1;
    assign reg_idx = reg_idx_t'(paddr[5:3]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            key_word_reg[0] <= 64'd0;
            key_word_reg[1] <= 64'd0;
            key_word_reg[2] <= 64'd0;
            key_word_reg[3] <= 64'd0;
            key_length_reg  <= KEY_LEN_RESET;
        end
        else if (wr_en) begin
            unique case (reg_idx)
                REG_KEY_WORD_0: key_word_reg[0] <= pwdata;
                REG_KEY_WORD_1: key_word_reg[1] <= pwdata;
                REG_KEY_WORD_2: key_word_reg[2] <= pwdata;
                REG_KEY_WORD_3: key_word_reg[3] <= pwdata;
                REG_KEY_LENGTH: key_length_reg  <= pwdata[5:0];
                default:        ; // unmapped: drop the write
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_idx)
            REG_KEY_WORD_0: prdata = key_word_reg[0];
            REG_KEY_WORD_1: prdata = key_word_reg[1];
            REG_KEY_WORD_2: prdata = key_word_reg[2];
            REG_KEY_WORD_3: prdata = key_word_reg[3];
            REG_KEY_LENGTH: prdata = {58'd0, key_length_reg};
            default:        prdata = 64'd0;
        endcase
    end

    assign key_cfg = {key_word_reg[3], key_word_reg[2], key_word_reg[1], key_word_reg[0],
                      key_length_reg};

    // hold the input only while the command queue is full
    assign char_stall = q_status.full;
    assign accept     = char_valid && !char_stall;

    rc4hsc_front #(
        .MAX_MESSAGE_CHARS (MAX_MESSAGE_CHARS)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .hex_char (hex_char),
        .is_last  (is_last),
        .push     (push),
        .cmd      (push_cmd)
    );

    rc4hsc_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    rc4hsc_core #(
        .MAX_KEY_BYTES (MAX_KEY_BYTES)
    ) u_core (
        .clk            (clk),
        .rst_n          (rst_n),
        .key_cfg        (key_cfg),
        .q_status       (q_status),
        .head           (head),
        .pop            (pop),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .out_char       (out_char),
        .has_char       (has_char),
        .end_of_message (end_of_message),
        .overflow       (overflow)
    );

endmodule

`default_nettype wire

@@ rtl/rc4hsc_front.sv @@
// ============================================================================
// rc4hsc_front
// Character front end: pairs hex characters into bytes, counts and drops
// characters past the message limit, and issues work commands.
// ============================================================================
`default_nettype none

module rc4hsc_front
    import rc4hsc_pkg::*;
#(
    parameter int MAX_MESSAGE_CHARS = 512
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       accept,
    input  wire logic [7:0] hex_char,
    input  wire logic       is_last,
    output      logic       push,
    output      cmd_t       cmd
);

    localparam int CNT_W = $clog2(MAX_MESSAGE_CHARS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_MESSAGE_CHARS);

    logic             in_message_reg, in_message_next;
    logic             pair_half_reg, pair_half_next;
    logic [3:0]       high_nibble_reg, high_nibble_next;
    logic [CNT_W-1:0] char_count_reg, char_count_next;
    logic             dropped_reg, dropped_next;

    logic             first;
    logic             cur_half;
    logic [CNT_W-1:0] cur_count;
    logic             cur_drop;
    logic [3:0]       nib;

    always_comb
    begin
        first     = !in_message_reg;
        cur_half  = first ? 1'b0 : pair_half_reg;
        cur_count = first ? '0 : char_count_reg;
        cur_drop  = first ? 1'b0 : dropped_reg;
        nib       = hex_decode(hex_char);

        in_message_next  = in_message_reg;
        pair_half_next   = pair_half_reg;
        high_nibble_next = high_nibble_reg;
        char_count_next  = char_count_reg;
        dropped_next     = dropped_reg;

        cmd      = '0;
        cmd.ksa  = first;
        cmd.data = {high_nibble_reg, nib};
        push     = 1'b0;

        if (accept) begin
            in_message_next  = 1'b1;
            pair_half_next   = cur_half;
            char_count_next  = cur_count;
            dropped_next     = cur_drop;
            if (cur_count < CNT_MAX) begin
                char_count_next = cur_count + 1'b1;
                if (!cur_half) begin
                    high_nibble_next = nib;
                    pair_half_next   = 1'b1;
                end
                else begin
                    pair_half_next = 1'b0;
                    cmd.pair       = 1'b1;
                end
            end
            else begin
                dropped_next = 1'b1;
            end
            if (is_last) begin
                cmd.last         = 1'b1;
                cmd.ovf          = dropped_next;
                in_message_next  = 1'b0;
                pair_half_next   = 1'b0;
                high_nibble_next = 4'd0;
            end
            push = cmd.ksa || cmd.pair || cmd.last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_message_reg  <= 1'b0;
            pair_half_reg   <= 1'b0;
            high_nibble_reg <= 4'd0;
            char_count_reg  <= '0;
            dropped_reg     <= 1'b0;
        end
        else begin
            in_message_reg  <= in_message_next;
            pair_half_reg   <= pair_half_next;
            high_nibble_reg <= high_nibble_next;
            char_count_reg  <= char_count_next;
            dropped_reg     <= dropped_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/rc4hsc_fifo.sv @@
// ============================================================================
// rc4hsc_fifo
// Short command queue between the front end and the cipher core.
// ============================================================================
`default_nettype none

module rc4hsc_fifo
    import rc4hsc_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push,
    input  wire cmd_t push_cmd,
    input  wire logic pop,
    output      cmd_t head,
    output q_status_t status
);

    localparam int DEPTH = 4;
    localparam int AW    = $clog2(DEPTH);

    cmd_t          entry_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [AW:0]   count_reg, count_next;

    logic do_push;
    logic do_pop;

    always_comb
    begin
        status.full  = (count_reg == (AW+1)'(DEPTH));
        status.empty = (count_reg == '0);
        do_push      = push && !status.full;
        do_pop       = pop && !status.empty;
        head         = entry_reg[rd_ptr_reg];
        wr_ptr_next  = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next  = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next   = count_reg + (AW+1)'(do_push) - (AW+1)'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

`default_nettype wire

@@ rtl/rc4hsc_core.sv @@
// ============================================================================
// rc4hsc_core
// Cipher core: RC4 key schedule and keystream over a 256 x 8 state memory,
// byte encipher and hex result register.
// ============================================================================
`default_nettype none

module rc4hsc_core
    import rc4hsc_pkg::*;
#(
    parameter int MAX_KEY_BYTES = 32
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire key_cfg_t   key_cfg,
    input  wire q_status_t  q_status,
    input  wire cmd_t       head,
    output      logic       pop,
    output      logic       res_valid,
    input  wire logic       res_stall,
    output      logic [7:0] out_char,
    output      logic       has_char,
    output      logic       end_of_message,
    output      logic       overflow
);

    localparam logic [5:0] KEY_MAX = 6'(MAX_KEY_BYTES);

    state_t     state_reg, state_next;
    cmd_t       cmd_reg, cmd_next;
    logic [7:0] n_reg, n_next;
    logic [4:0] kpos_reg, kpos_next;
    logic [7:0] i_reg, i_next;
    logic [7:0] j_reg, j_next;
    logic [7:0] si_reg, si_next;
    logic [7:0] sj_reg, sj_next;

    logic       res_valid_reg, res_valid_next;
    logic [7:0] out_char_reg, out_char_next;
    logic       has_char_reg, has_char_next;
    logic       eom_reg, eom_next;
    logic       ovf_reg, ovf_next;

    // state memory, one write and one registered read per cycle
    logic [7:0] sbox_mem [256];
    logic [7:0] rdata_reg;
    logic       re;
    logic [7:0] raddr;
    logic       we;
    logic [7:0] waddr;
    logic [7:0] wdata;

    logic [5:0] eff_len;
    logic [7:0] key_byte;
    logic [7:0] j_sum;
    logic [7:0] cipher;
    logic       out_free;

    always_comb
    begin
        if (key_cfg.len == 6'd0) begin
            eff_len = 6'd1;
        end
        else if (key_cfg.len > KEY_MAX) begin
            eff_len = KEY_MAX;
        end
        else begin
            eff_len = key_cfg.len;
        end
        key_byte = key_cfg.key[{kpos_reg, 3'b000} +: 8];
        cipher   = cmd_reg.data ^ rdata_reg;
        out_free = !res_valid_reg || !res_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            res_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg      <= cmd_next;
        n_reg        <= n_next;
        kpos_reg     <= kpos_next;
        i_reg        <= i_next;
        j_reg        <= j_next;
        si_reg       <= si_next;
        sj_reg       <= sj_next;
        out_char_reg <= out_char_next;
        has_char_reg <= has_char_next;
        eom_reg      <= eom_next;
        ovf_reg      <= ovf_next;
    end

    always_ff @(posedge clk)
    begin
        if (we) begin
            sbox_mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= sbox_mem[raddr];
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        n_next         = n_reg;
        kpos_next      = kpos_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        si_next        = si_reg;
        sj_next        = sj_reg;
        out_char_next  = out_char_reg;
        has_char_next  = has_char_reg;
        eom_next       = eom_reg;
        ovf_next       = ovf_reg;
        res_valid_next = (res_valid_reg && res_stall);
        pop            = 1'b0;
        re             = 1'b0;
        raddr          = n_reg;
        we             = 1'b0;
        waddr          = n_reg;
        wdata          = n_reg;
        j_sum          = j_reg + rdata_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (!q_status.empty) begin
                    pop      = 1'b1;
                    cmd_next = head;
                    n_next   = 8'd0;
                    if (head.ksa) begin
                        state_next = ST_INIT;
                    end
                    else if (head.pair) begin
                        state_next = ST_GEN_RD_I;
                    end
                    else if (head.last) begin
                        state_next = ST_OUT_END;
                    end
                end
            end
            ST_INIT:
            begin
                // identity fill
                we     = 1'b1;
                n_next = n_reg + 8'd1;
                if (n_reg == 8'hFF) begin
                    j_next     = 8'd0;
                    kpos_next  = 5'd0;
                    state_next = ST_KSA_RD_I;
                end
            end
            ST_KSA_RD_I:
            begin
                re         = 1'b1;
                state_next = ST_KSA_RD_J;
            end
            ST_KSA_RD_J:
            begin
                si_next    = rdata_reg;
                j_next     = j_reg + rdata_reg + key_byte;
                raddr      = j_next;
                re         = 1'b1;
                state_next = ST_KSA_WR_I;
            end
            ST_KSA_WR_I:
            begin
                we         = 1'b1;
                wdata      = rdata_reg;
                state_next = ST_KSA_WR_J;
            end
            ST_KSA_WR_J:
            begin
                we     = 1'b1;
                waddr  = j_reg;
                wdata  = si_reg;
                n_next = n_reg + 8'd1;
                if ({1'b0, kpos_reg} + 6'd1 >= eff_len) begin
                    kpos_next = 5'd0;
                end
                else begin
                    kpos_next = kpos_reg + 5'd1;
                end
                if (n_reg == 8'hFF) begin
                    i_next = 8'd0;
                    j_next = 8'd0;
                    if (cmd_reg.pair) begin
                        state_next = ST_GEN_RD_I;
                    end
                    else if (cmd_reg.last) begin
                        state_next = ST_OUT_END;
                    end
                    else begin
                        state_next = ST_IDLE;
                    end
                end
                else begin
                    state_next = ST_KSA_RD_I;
                end
            end
            ST_GEN_RD_I:
            begin
                i_next     = i_reg + 8'd1;
                raddr      = i_next;
                re         = 1'b1;
                state_next = ST_GEN_RD_J;
            end
            ST_GEN_RD_J:
            begin
                si_next    = rdata_reg;
                j_next     = j_sum;
                raddr      = j_sum;
                re         = 1'b1;
                state_next = ST_GEN_WR_I;
            end
            ST_GEN_WR_I:
            begin
                sj_next    = rdata_reg;
                we         = 1'b1;
                waddr      = i_reg;
                wdata      = rdata_reg;
                state_next = ST_GEN_WR_J;
            end
            ST_GEN_WR_J:
            begin
                we         = 1'b1;
                waddr      = j_reg;
                wdata      = si_reg;
                state_next = ST_GEN_RD_K;
            end
            ST_GEN_RD_K:
            begin
                // keystream byte lands in rdata_reg and holds for both results
                raddr      = si_reg + sj_reg;
                re         = 1'b1;
                state_next = ST_OUT_HI;
            end
            ST_OUT_HI:
            begin
                if (out_free) begin
                    res_valid_next = 1'b1;
                    out_char_next  = hex_encode(cipher[7:4]);
                    has_char_next  = 1'b1;
                    eom_next       = 1'b0;
                    ovf_next       = 1'b0;
                    state_next     = ST_OUT_LO;
                end
            end
            ST_OUT_LO:
            begin
                if (out_free) begin
                    res_valid_next = 1'b1;
                    out_char_next  = hex_encode(cipher[3:0]);
                    has_char_next  = 1'b1;
                    eom_next       = cmd_reg.last;
                    ovf_next       = cmd_reg.last && cmd_reg.ovf;
                    state_next     = ST_IDLE;
                end
            end
            ST_OUT_END:
            begin
                if (out_free) begin
                    res_valid_next = 1'b1;
                    out_char_next  = 8'd0;
                    has_char_next  = 1'b0;
                    eom_next       = 1'b1;
                    ovf_next       = cmd_reg.ovf;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign res_valid      = res_valid_reg;
    assign out_char       = out_char_reg;
    assign has_char       = has_char_reg;
    assign end_of_message = eom_reg;
    assign overflow       = ovf_reg;

endmodule

`default_nettype wire

@@ rtl/rc4hsc_checker.sv @@
// ============================================================================
// rc4hsc_checker
// Port-level checks on the result channel of the RC4 hex stream cipher.
// ============================================================================
`default_nettype none

module rc4hsc_checker
(
    input wire logic       clk,
    input wire logic       rst_n,
    input wire logic       res_valid,
    input wire logic       res_stall,
    input wire logic [7:0] out_char,
    input wire logic       has_char,
    input wire logic       end_of_message,
    input wire logic       overflow
);

    // a stalled result stays put
    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid && $stable(out_char) && $stable(has_char)
            && $stable(end_of_message) && $stable(overflow))
        else $error("result changed while stalled");

    // an empty result only closes a message
    a_empty_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !has_char |-> end_of_message && out_char == 8'd0)
        else $error("empty result outside message end");

    // overflow is reported on the final result only
    a_ovf_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && overflow |-> end_of_message)
        else $error("overflow on a non-final result");

    // characters are lowercase hex digits
    a_hex_char: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && has_char |->
            (out_char >= 8'h30 && out_char <= 8'h39) ||
            (out_char >= 8'h61 && out_char <= 8'h66))
        else $error("result is not a lowercase hex digit");

endmodule

bind rc4_hex_stream_cipher rc4hsc_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .out_char       (out_char),
    .has_char       (has_char),
    .end_of_message (end_of_message),
    .overflow       (overflow)
);

`default_nettype wire

@@ verif/tb_rc4_hex_stream_cipher.sv @@
// ============================================================================
// tb_rc4_hex_stream_cipher
// Self-checking testbench for the RC4 hex stream cipher.
// ============================================================================
// Messages of ASCII characters go in through a queue-fed driver. A predictor
// runs its own RC4 key schedule and keystream over the same key registers and
// works out the hex characters that each accepted character must produce.
// A monitor takes results, compares them field by field with the oldest
// expected result, and counts mismatches. Key registers are reprogrammed
// over the APB port between phases, only after the block has gone idle.
// A short directed part covers odd tails, non-hex characters and both letter
// cases; the random part mixes short messages with two long ones, one that
// reaches or passes the message length limit and one past it. Both channels
// idle at random, the receiver once holds off long enough to back the block
// up, and the sender once pauses until every pending result has drained.
// ============================================================================

module tb_rc4_hex_stream_cipher;

    timeunit 1ns;
    timeprecision 1ps;

    import rc4hsc_pkg::*;

    localparam int MSG_CHARS_MAX  = 512;
    localparam int KEY_BYTES_MAX  = 32;
    localparam int SETTLE_CYCLES  = 1400;   // longer than one key schedule
    localparam int HOLD_CYCLES    = 2000;   // receiver hold-off stretch
    localparam int QUIET_LIMIT    = 10000;  // cycles with no transaction
    localparam int PHASES         = 8;
    localparam int SHORT_PER_PHASE = 100;
    localparam int PRINT_LIMIT    = 100;

    // One character transaction waiting to be driven
    typedef struct {
        logic [7:0] ch;
        logic       last;
        bit         pause;  // hold this one back until all results are in
    } char_txn_t;

    // One result transaction as the block should produce it
    typedef struct packed {
        logic [7:0] ch;
        logic       has;
        logic       fin;
        logic       ovf;
    } cipher_res_t;

    // ------------------------------------------------------------------------
    // Clock, reset and DUT signals
    // ------------------------------------------------------------------------
    logic        clk = 1'b0;
    logic        rst_n = 1'b0;

    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    logic        char_valid = 1'b0;
    logic        char_stall;
    logic [7:0]  hex_char = '0;
    logic        is_last = 1'b0;

    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [7:0]  out_char;
    logic        has_char;
    logic        end_of_message;
    logic        overflow;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    rc4_hex_stream_cipher uut (
        .clk            (clk),
        .rst_n          (rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .char_valid     (char_valid),
        .char_stall     (char_stall),
        .hex_char       (hex_char),
        .is_last        (is_last),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .out_char       (out_char),
        .has_char       (has_char),
        .end_of_message (end_of_message),
        .overflow       (overflow)
    );

    // ------------------------------------------------------------------------
    // Shared testbench state
    // ------------------------------------------------------------------------
    char_txn_t   char_pending[$];   // characters still to be driven
    cipher_res_t cipher_expect[$];  // results owed by the block, oldest first
    int          chars_sent = 0;
    int          results_seen = 0;
    int          mismatches = 0;
    bit          hold_request = 1'b0;
    logic        hold_on = 1'b0;

    // Predictor copy of the key registers
    logic [63:0] key_word [4];
    logic [5:0]  key_len;

    // Predictor copy of the cipher state
    logic [7:0]  sbox [256];
    logic [7:0]  ks_i;
    logic [7:0]  ks_j;
    logic [3:0]  pend_hi;
    bit          pend_half;
    bit          msg_open;
    bit          msg_dropped;
    int          msg_chars;

    // ------------------------------------------------------------------------
    // Cipher predictor
    // ------------------------------------------------------------------------
    function automatic logic [7:0] key_byte_at(int k);
        return key_word[k >> 3][(k & 7) * 8 +: 8];
    endfunction

    // Standard RC4 key schedule over the programmed key bytes
    function automatic void schedule_key();
        int         len;
        int         kpos;
        logic [7:0] j;
        logic [7:0] t;
        len = key_len;
        if (len == 0) len = 1;
        if (len > KEY_BYTES_MAX) len = KEY_BYTES_MAX;
        for (int n = 0; n < 256; n++) sbox[n] = 8'(n);
        j = '0;
        kpos = 0;
        for (int n = 0; n < 256; n++)
        begin
            j = j + sbox[n] + key_byte_at(kpos);
            t = sbox[n];
            sbox[n] = sbox[j];
            sbox[j] = t;
            kpos++;
            if (kpos >= len) kpos = 0;
        end
        ks_i = '0;
        ks_j = '0;
    endfunction

    function automatic logic [7:0] next_pad();
        logic [7:0] t;
        ks_i = ks_i + 8'd1;
        ks_j = ks_j + sbox[ks_i];
        t = sbox[ks_i];
        sbox[ks_i] = sbox[ks_j];
        sbox[ks_j] = t;
        return sbox[8'(sbox[ks_i] + sbox[ks_j])];
    endfunction

    // Non-hex characters count as zero
    function automatic logic [3:0] nibble_of(logic [7:0] c);
        logic [7:0] u;
        u = c & 8'hDF;
        if (c >= "0" && c <= "9") return 4'(c - "0");
        if (u >= "A" && u <= "F") return 4'(u - "A" + 8'd10);
        return 4'd0;
    endfunction

    function automatic logic [7:0] hex_of(logic [3:0] n);
        if (n < 4'd10) return 8'("0" + n);
        return 8'("a" + n - 4'd10);
    endfunction

    // Advance the cipher by one accepted character and queue its results
    function automatic void predict_cipher_text(logic [7:0] ch, logic last);
        cipher_res_t hi_res;
        cipher_res_t lo_res;
        logic [7:0]  b;
        bit          paired;
        paired = 1'b0;
        if (!msg_open)
        begin
            schedule_key();
            pend_hi = '0;
            pend_half = 1'b0;
            msg_chars = 0;
            msg_dropped = 1'b0;
            msg_open = 1'b1;
        end
        if (msg_chars < MSG_CHARS_MAX)
        begin
            msg_chars++;
            if (!pend_half)
            begin
                pend_hi = nibble_of(ch);
                pend_half = 1'b1;
            end
            else
            begin
                b = {pend_hi, nibble_of(ch)} ^ next_pad();
                pend_half = 1'b0;
                hi_res = '{ch: hex_of(b[7:4]), has: 1'b1, fin: 1'b0, ovf: 1'b0};
                lo_res = '{ch: hex_of(b[3:0]), has: 1'b1, fin: 1'b0, ovf: 1'b0};
                paired = 1'b1;
            end
        end
        else
        begin
            msg_dropped = 1'b1;
        end
        if (paired)
        begin
            if (last)
            begin
                lo_res.fin = 1'b1;
                lo_res.ovf = msg_dropped;
            end
            cipher_expect.push_back(hi_res);
            cipher_expect.push_back(lo_res);
        end
        else if (last)
        begin
            // unpaired end: one empty closing result
            cipher_expect.push_back('{ch: 8'h00, has: 1'b0, fin: 1'b1, ovf: msg_dropped});
        end
        if (last)
        begin
            msg_open = 1'b0;
            pend_half = 1'b0;
            pend_hi = '0;
        end
    endfunction

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic void queue_char(logic [7:0] ch, logic last, bit pause);
        char_txn_t txn;
        txn.ch = ch;
        txn.last = last;
        txn.pause = pause;
        char_pending.push_back(txn);
    endfunction

    function automatic void queue_text(string s);
        for (int k = 0; k < s.len(); k++)
            queue_char(s[k], k == s.len() - 1, 1'b0);
    endfunction

    // Mostly well-formed hex with some raw byte noise mixed in
    function automatic logic [7:0] pick_char();
        int r;
        r = $urandom_range(0, 9);
        if (r < 4) return 8'("0" + $urandom_range(0, 9));
        if (r < 6) return 8'("a" + $urandom_range(0, 5));
        if (r < 8) return 8'("A" + $urandom_range(0, 5));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic void queue_message(int len, bit pause);
        for (int k = 0; k < len; k++)
            queue_char(pick_char(), k == len - 1, pause && k == 0);
    endfunction

    // APB write: setup cycle, then access cycle until pready
    task automatic reg_write(reg_idx_t idx, logic [63:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_KEY_LENGTH) key_len = value[5:0];
        else key_word[idx[1:0]] = value;
    endtask

    // Key setting per phase: extremes first, then random lengths
    task automatic program_keys(int phase);
        logic [63:0] w [4];
        logic [5:0]  len;
        for (int k = 0; k < 4; k++)
            w[k] = (phase == 0) ? '1 : {$urandom(), $urandom()};
        case (phase)
            0: len = 6'd32;
            1: len = 6'd1;
            2: len = 6'd0;   // read as one byte
            3: len = 6'd63;  // clamped to the key size
            default: len = 6'($urandom_range(1, KEY_BYTES_MAX));
        endcase
        reg_write(REG_KEY_WORD_0, w[0]);
        reg_write(REG_KEY_WORD_1, w[1]);
        reg_write(REG_KEY_WORD_2, w[2]);
        reg_write(REG_KEY_WORD_3, w[3]);
        reg_write(REG_KEY_LENGTH, {58'd0, len});
    endtask

    // Wait until everything queued has gone through, then let the core settle
    task automatic drain_and_settle();
        @(negedge clk);
        while (char_pending.size() != 0 || char_valid || cipher_expect.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic report_mismatch(string field, logic [7:0] got, logic [7:0] want);
        if (mismatches < PRINT_LIMIT)
            $display("[%0t] result %0d: %s got %0h, want %0h",
                     $realtime, results_seen, field, got, want);
        mismatches++;
    endtask

    // ------------------------------------------------------------------------
    // Character driver: pop a transaction, hold it while stalled, then wait a
    // random gap before offering the next one. Burst mode drops the gaps.
    // ------------------------------------------------------------------------
    int gap_left = 0;
    bit tx_burst = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin : char_driver
        bit        taken;
        char_txn_t txn;
        if (!rst_n)
        begin
            char_valid <= 1'b0;
            hex_char   <= '0;
            is_last    <= 1'b0;
            gap_left = 0;
        end
        else
        begin
            taken = char_valid && !char_stall;
            if (taken)
            begin
                predict_cipher_text(hex_char, is_last);
                chars_sent++;
                if ($urandom_range(0, 63) == 0) tx_burst = !tx_burst;
                gap_left = tx_burst ? 0 : $urandom_range(0, 5);
            end
            // a stalled transaction stays on the bus untouched
            if (!char_valid || taken)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    char_valid <= 1'b0;
                end
                else if (char_pending.size() != 0 &&
                         !(char_pending[0].pause && cipher_expect.size() != 0))
                begin
                    txn = char_pending.pop_front();
                    char_valid <= 1'b1;
                    hex_char   <= txn.ch;
                    is_last    <= txn.last;
                end
                else
                begin
                    char_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Result monitor: check each accepted result against the oldest
    // expectation, then draw how long to stall the next one.
    // ------------------------------------------------------------------------
    int stall_left = 0;
    bit rx_burst = 1'b0;

    always @(posedge clk or negedge rst_n)
    begin : result_monitor
        cipher_res_t want;
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            stall_left = 0;
        end
        else
        begin
            if (res_valid && !res_stall)
            begin
                if (cipher_expect.size() == 0)
                begin
                    report_mismatch("unexpected result, out_char", out_char, 8'h00);
                end
                else
                begin
                    want = cipher_expect.pop_front();
                    if (out_char !== want.ch)
                        report_mismatch("out_char", out_char, want.ch);
                    if (has_char !== want.has)
                        report_mismatch("has_char", 8'(has_char), 8'(want.has));
                    if (end_of_message !== want.fin)
                        report_mismatch("end_of_message", 8'(end_of_message), 8'(want.fin));
                    if (overflow !== want.ovf)
                        report_mismatch("overflow", 8'(overflow), 8'(want.ovf));
                end
                results_seen++;
                if ($urandom_range(0, 63) == 0) rx_burst = !rx_burst;
                stall_left = rx_burst ? 0 : $urandom_range(0, 5);
            end
            else if (res_valid && stall_left > 0)
            begin
                stall_left--;
            end
            res_stall <= (stall_left > 0) || hold_on;
        end
    end

    // ------------------------------------------------------------------------
    // Long receiver hold-off, counted here so the block backs up to its input
    // ------------------------------------------------------------------------
    int hold_cycles = 0;

    always @(posedge clk or negedge rst_n)
    begin : rx_holdoff
        if (!rst_n)
        begin
            hold_on <= 1'b0;
            hold_cycles = 0;
        end
        else
        begin
            if (hold_request)
            begin
                hold_cycles = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            else if (hold_cycles > 0)
            begin
                hold_cycles--;
            end
            hold_on <= (hold_cycles > 0);
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run if no transaction moves for too long
    // ------------------------------------------------------------------------
    int quiet_cycles = 0;

    always @(posedge clk)
    begin : watchdog
        if (rst_n && !(char_valid && !char_stall) && !(res_valid && !res_stall))
            quiet_cycles++;
        else
            quiet_cycles = 0;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("watchdog: no transaction for %0d cycles, %0d results owed",
                     quiet_cycles, cipher_expect.size());
            $display("end of test: mismatches");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Test sequence
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        int queued;
        int msgs;
        int mark;
        int len;

        // predictor starts from the register reset values and a cleared state
        for (int k = 0; k < 4; k++) key_word[k] = '0;
        key_len = KEY_LEN_RESET;
        for (int n = 0; n < 256; n++) sbox[n] = '0;
        ks_i = '0;
        ks_j = '0;
        pend_hi = '0;
        pend_half = 1'b0;
        msg_open = 1'b0;
        msg_dropped = 1'b0;
        msg_chars = 0;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Directed part on the reset key setting
        @(negedge clk);
        queue_text("0");                 // lone character: empty closing result
        queue_char(8'h00, 1'b0, 1'b0);   // raw byte extremes read as zero
        queue_char(8'hFF, 1'b1, 1'b0);
        queue_text("9afAFGg/:");         // digit and letter edges, odd tail
        queue_text("@`09Fe");            // neighbors of the hex ranges, even end
        drain_and_settle();

        // Random part, one key setting per phase
        for (int ph = 0; ph < PHASES; ph++)
        begin
            program_keys(ph);
            @(negedge clk);
            // run one message that reaches or passes the length limit and one past it
            if (ph == 2) queue_message($urandom_range(MSG_CHARS_MAX, MSG_CHARS_MAX + 4), 1'b0);
            if (ph == 5) queue_message($urandom_range(MSG_CHARS_MAX + 1, MSG_CHARS_MAX + 8), 1'b0);
            queued = 0;
            msgs = 0;
            while (queued < SHORT_PER_PHASE)
            begin
                len = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 2) : $urandom_range(1, 24);
                // in phase 3 the sender waits for a full drain before the fourth message
                queue_message(len, ph == 3 && msgs == 3);
                queued += len;
                msgs++;
            end
            if (ph == 1)
            begin
                // hold the receiver off while characters are still on offer
                mark = chars_sent + 12;
                while (chars_sent < mark) @(negedge clk);
                hold_request = 1'b1;
            end
            drain_and_settle();
        end

        if (mismatches == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/rc4hsc_pkg.sv
rtl/rc4hsc_front.sv
rtl/rc4hsc_fifo.sv
rtl/rc4hsc_core.sv
rtl/rc4_hex_stream_cipher.sv
rtl/rc4hsc_checker.sv
verif/tb_rc4_hex_stream_cipher.sv
